// ----- design/lca_pkg.sv -----
`timescale 1ns / 1ps

package lca_pkg;

    // Sizes of the weight store and of the score file
    localparam int MAX_FEATURES = 64;
    localparam int MAX_CLASSES  = 16;

    // Field widths; the index fields span the store exactly
    localparam int FEAT_W  = $clog2(MAX_FEATURES);
    localparam int CLS_W   = $clog2(MAX_CLASSES);
    localparam int ADDR_W  = CLS_W + FEAT_W;
    localparam int VAL_W   = 16;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int SCORE_W = 40;
    localparam int CNT_W   = 7;
    localparam int CCNT_W  = 5;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Configuration port
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    localparam logic [REG_IDX_W-1:0] REG_FEATURE_COUNT = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_CLASS_COUNT   = 1'b1;

    // Item opcodes
    localparam logic OP_WEIGHT  = 1'b0;
    localparam logic OP_FEATURE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_CHECK,
        ST_SCAN,
        ST_RESULT
    } lca_state_t;

    // Control from the sequencer to the shared multiply-accumulate unit
    typedef struct packed {
        logic             mul_en;
        logic [CLS_W-1:0] mul_cls;
        logic             clear;
        logic [CLS_W-1:0] scan_idx;
    } mac_ctrl_t;

endpackage

// ----- design/lca_if.sv -----
`timescale 1ns / 1ps

interface lca_item_if;
    import lca_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [CLS_W-1:0]         class_index;
    logic [FEAT_W-1:0]        feature_index;
    logic signed [VAL_W-1:0]  value;
    logic                     last;

    modport source (output valid, op, class_index, feature_index, value, last, input ready);
    modport sink   (input valid, op, class_index, feature_index, value, last, output ready);
endinterface

interface lca_result_if;
    import lca_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [CLS_W-1:0]          predicted_class;
    logic signed [SCORE_W-1:0] best_score;
    logic                      length_error;

    modport source (output valid, predicted_class, best_score, length_error, input ready);
    modport sink   (input valid, predicted_class, best_score, length_error, output ready);
endinterface

// ----- design/lca_weight_ram.sv -----
`timescale 1ns / 1ps

module lca_weight_ram (
    input  logic                             clk,
    input  logic                             we,
    input  logic [lca_pkg::ADDR_W-1:0]       addr,
    input  logic signed [lca_pkg::VAL_W-1:0] wdata,
    output logic signed [lca_pkg::VAL_W-1:0] rdata
);
    import lca_pkg::*;

    logic signed [VAL_W-1:0] mem [MAX_CLASSES*MAX_FEATURES];
    logic signed [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/lca_mac.sv -----
`timescale 1ns / 1ps

module lca_mac (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lca_pkg::mac_ctrl_t                 ctrl,
    input  logic signed [lca_pkg::VAL_W-1:0]   weight,
    input  logic signed [lca_pkg::VAL_W-1:0]   feature,
    output logic signed [lca_pkg::SCORE_W-1:0] scan_score,
    output logic                               busy
);
    import lca_pkg::*;

    logic                      mul_vld_reg, mul_vld_next;
    logic [CLS_W-1:0]          mul_cls_reg, mul_cls_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [SCORE_W-1:0] score_reg [MAX_CLASSES];
    logic signed [SCORE_W-1:0] score_next;
    logic [MAX_CLASSES-1:0]    valid_reg, valid_next;
    logic [CLS_W-1:0]          idx;
    logic signed [SCORE_W-1:0] cur;

    // One read port: the accumulate slot when a product is waiting, else the scan slot
    assign idx = mul_vld_reg ? mul_cls_reg : ctrl.scan_idx;
    assign cur = valid_reg[idx] ? score_reg[idx] : '0;

    always_comb
    begin
        mul_vld_next = ctrl.mul_en;
        mul_cls_next = ctrl.mul_cls;
        prod_next    = weight * feature;
        score_next   = cur + {{(SCORE_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        valid_next   = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = '0;
        end
        else if (mul_vld_reg)
        begin
            valid_next[idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_vld_reg <= 1'b0;
            valid_reg   <= '0;
        end
        else
        begin
            mul_vld_reg <= mul_vld_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_cls_reg <= mul_cls_next;
        prod_reg    <= prod_next;
        if (mul_vld_reg)
        begin
            score_reg[mul_cls_reg] <= score_next;
        end
    end

    assign scan_score = cur;
    assign busy       = mul_vld_reg;

endmodule

// ----- design/linear_classifier_argmax.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Word fields                                           Handshake
// -------   ---  ----------------------------------------------------  ---------
// item      in   op, class_index, feature_index, value (Q4.12), last    valid/ready
// result    out  predicted_class, best_score (Q16.24), length_error     valid/ready
// apb       in   feature_count @ 0x0, class_count @ 0x4                 psel/penable
//
// A weight word is written straight into the weight store. For a feature word,
// the weight RAM port and the single multiplier serve one class per cycle over
// the active classes (at most 16), then the pipeline drains and the sequencer
// returns to idle. An element that scores nothing (excess, or no classes) is only
// counted. A word marked last then runs the argmax scan through the same score
// read port (skipped when the result is forced), plus a wait while the result
// register is still full.
// Reset clears control state and the score valid bits; the weight store is not
// cleared. Ready is high only in the idle state; a pending result does not stop
// weight or feature words until the next result is due.

module linear_classifier_argmax (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lca_pkg::APB_AW-1:0]        paddr,
    input  logic [lca_pkg::APB_DW-1:0]        pwdata,
    output logic [lca_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    lca_item_if.sink                          item,
    lca_result_if.source                      result
);
    import lca_pkg::*;

    lca_state_t state_reg, state_next;

    logic [CNT_W-1:0]          feature_count_reg, feature_count_next;
    logic [CCNT_W-1:0]         class_count_reg, class_count_next;
    logic [CNT_W-1:0]          elements_seen_reg, elements_seen_next;
    logic                      overrun_reg, overrun_next;
    logic signed [VAL_W-1:0]   value_reg, value_next;
    logic [FEAT_W-1:0]         pos_reg, pos_next;
    logic                      last_reg, last_next;
    logic [CCNT_W-1:0]         issue_cls_reg, issue_cls_next;
    logic                      rd_vld_reg, rd_vld_next;
    logic [CLS_W-1:0]          rd_cls_reg, rd_cls_next;
    logic                      len_err_reg, len_err_next;
    logic [CLS_W-1:0]          scan_idx_reg, scan_idx_next;
    logic signed [SCORE_W-1:0] best_reg, best_next;
    logic [CLS_W-1:0]          best_cls_reg, best_cls_next;
    logic                      out_valid_reg, out_valid_next;
    logic [CLS_W-1:0]          out_cls_reg, out_cls_next;
    logic signed [SCORE_W-1:0] out_score_reg, out_score_next;
    logic                      out_len_reg, out_len_next;

    logic [CCNT_W-1:0]         active;
    logic                      in_ready, feat_acc, wr_acc, do_mac, chk_err;
    logic                      issue_en, issue_done, scan_done, res_load;
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_addr;
    logic signed [VAL_W-1:0]   ram_rdata;
    logic signed [SCORE_W-1:0] scan_score;
    logic                      mac_busy;
    mac_ctrl_t                 mac_ctrl;
    logic                      cfg_we;
    logic [REG_IDX_W-1:0]      cfg_idx;

    // ------------------------------------------------------------------
    // Configuration port: pready is held high, writes land in the access cycle
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[APB_AW-1:2];

    always_comb
    begin
        case (cfg_idx)
            REG_FEATURE_COUNT: prdata = APB_DW'(feature_count_reg);
            REG_CLASS_COUNT:   prdata = APB_DW'(class_count_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb
    begin
        feature_count_next = feature_count_reg;
        class_count_next   = class_count_reg;
        if (cfg_we && cfg_idx == REG_FEATURE_COUNT)
        begin
            feature_count_next = pwdata[CNT_W-1:0];
        end
        if (cfg_we && cfg_idx == REG_CLASS_COUNT)
        begin
            class_count_next = pwdata[CCNT_W-1:0];
        end
    end

    // Clamp the class count to the size of the score file
    assign active = (class_count_reg < CCNT_W'(MAX_CLASSES)) ? class_count_reg
                                                              : CCNT_W'(MAX_CLASSES);

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    assign wr_acc   = item.valid && in_ready && (item.op == OP_WEIGHT);
    assign feat_acc = item.valid && in_ready && (item.op == OP_FEATURE);

    // Excess elements are counted but score nothing
    assign do_mac = (elements_seen_reg < feature_count_reg)
                 && (elements_seen_reg < CNT_W'(MAX_FEATURES))
                 && (active != '0);

    assign chk_err    = overrun_reg || (elements_seen_reg != feature_count_reg);
    assign issue_done = (issue_cls_reg == active);
    assign scan_done  = ({1'b0, scan_idx_reg} == active - CCNT_W'(1));

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (feat_acc)
                begin
                    if (do_mac)
                    begin
                        state_next = ST_MAC;
                    end
                    else if (item.last)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_MAC:
            begin
                // Leave only once the last product has been added
                if (issue_done && !rd_vld_reg && !mac_busy)
                begin
                    state_next = last_reg ? ST_CHECK : ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                state_next = (chk_err || active == '0) ? ST_RESULT : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready = 1'b0;
        issue_en = 1'b0;
        res_load = 1'b0;
        case (state_reg)
            ST_IDLE:   in_ready = 1'b1;
            ST_MAC:    issue_en = !issue_done;
            ST_RESULT: res_load = !out_valid_reg || result.ready;
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign item.ready = in_ready;

    // ------------------------------------------------------------------
    // Weight store: written by weight words, read one class per cycle
    // ------------------------------------------------------------------
    assign ram_we   = wr_acc;
    assign ram_addr = ram_we ? {item.class_index, item.feature_index}
                             : {issue_cls_reg[CLS_W-1:0], pos_reg};

    lca_weight_ram u_weight_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (item.value),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Shared multiply-accumulate unit and score file
    // ------------------------------------------------------------------
    always_comb
    begin
        mac_ctrl.mul_en   = rd_vld_reg;
        mac_ctrl.mul_cls  = rd_cls_reg;
        mac_ctrl.clear    = res_load;
        mac_ctrl.scan_idx = scan_idx_reg;
    end

    lca_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (mac_ctrl),
        .weight     (ram_rdata),
        .feature    (value_reg),
        .scan_score (scan_score),
        .busy       (mac_busy)
    );

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        elements_seen_next = elements_seen_reg;
        overrun_next       = overrun_reg;
        value_next         = value_reg;
        pos_next           = pos_reg;
        last_next          = last_reg;
        issue_cls_next     = issue_cls_reg;
        len_err_next       = len_err_reg;
        scan_idx_next      = scan_idx_reg;
        best_next          = best_reg;
        best_cls_next      = best_cls_reg;

        // Latch the element and advance the count, saturating into overrun
        if (feat_acc)
        begin
            value_next = item.value;
            pos_next   = elements_seen_reg[FEAT_W-1:0];
            last_next  = item.last;
            if (elements_seen_reg == COUNT_MAX)
            begin
                overrun_next = 1'b1;
            end
            else
            begin
                elements_seen_next = elements_seen_reg + CNT_W'(1);
            end
        end

        if (state_reg == ST_IDLE)
        begin
            issue_cls_next = '0;
        end
        else if (issue_en)
        begin
            issue_cls_next = issue_cls_reg + CCNT_W'(1);
        end

        // Forced result is class 0 with a zero score
        if (state_reg == ST_CHECK)
        begin
            len_err_next  = chk_err;
            scan_idx_next = '0;
            best_next     = '0;
            best_cls_next = '0;
        end

        // First class with the strictly largest score wins
        if (state_reg == ST_SCAN)
        begin
            scan_idx_next = scan_idx_reg + CLS_W'(1);
            if (scan_idx_reg == '0 || scan_score > best_reg)
            begin
                best_next     = scan_score;
                best_cls_next = scan_idx_reg;
            end
        end

        // Drop the vector state once the result is handed over
        if (res_load)
        begin
            elements_seen_next = '0;
            overrun_next       = 1'b0;
        end
    end

    assign rd_vld_next = issue_en;
    assign rd_cls_next = issue_cls_reg[CLS_W-1:0];

    // ------------------------------------------------------------------
    // Result register: holds a finished word until the sink takes it
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_cls_next   = out_cls_reg;
        out_score_next = out_score_reg;
        out_len_next   = out_len_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
            out_cls_next   = best_cls_reg;
            out_score_next = best_reg;
            out_len_next   = len_err_reg;
        end
        else if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.predicted_class = out_cls_reg;
    assign result.best_score      = out_score_reg;
    assign result.length_error    = out_len_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            feature_count_reg <= '0;
            class_count_reg   <= '0;
            elements_seen_reg <= '0;
            overrun_reg       <= 1'b0;
            issue_cls_reg     <= '0;
            rd_vld_reg        <= 1'b0;
            scan_idx_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            feature_count_reg <= feature_count_next;
            class_count_reg   <= class_count_next;
            elements_seen_reg <= elements_seen_next;
            overrun_reg       <= overrun_next;
            issue_cls_reg     <= issue_cls_next;
            rd_vld_reg        <= rd_vld_next;
            scan_idx_reg      <= scan_idx_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        pos_reg       <= pos_next;
        last_reg      <= last_next;
        rd_cls_reg    <= rd_cls_next;
        len_err_reg   <= len_err_next;
        best_reg      <= best_next;
        best_cls_reg  <= best_cls_next;
        out_cls_reg   <= out_cls_next;
        out_score_reg <= out_score_next;
        out_len_reg   <= out_len_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The multiply-accumulate pipeline is empty whenever a word can be taken
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!rd_vld_reg && !mac_busy))
        else $error("word accepted while products still in flight");

    // A length error always carries the forced class 0 and zero score
    a_forced_result: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.length_error)
            |-> (result.predicted_class == '0 && result.best_score == '0))
        else $error("length error without forced result");

    // Overrun is only ever set with the count saturated
    a_overrun_sat: assert property (@(posedge clk) disable iff (!rst_n)
        overrun_reg |-> (elements_seen_reg == COUNT_MAX))
        else $error("overrun flag without saturated count");

    // Handing over a result clears the vector state
    a_vector_clear: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (elements_seen_reg == '0 && !overrun_reg))
        else $error("vector state not cleared after result");

endmodule
